// ===== sv/msort_pkg.sv =====
package msort_pkg;

  // Fixed field width of the element values
  localparam int VALUE_BITS    = 32;
  // Default batch capacity
  localparam int MAX_ITEMS_DEF = 64;

  // Input beat: one element, last marks the close of the batch
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;
  } msort_in_t;

  // Result beat: next element in ascending order, final_res on the greatest
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] sorted_value;
    logic                         final_res;
  } msort_out_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_CAP_A,
    S_CAP_B,
    S_MERGE,
    S_REFILL,
    S_NEXT,
    S_EMIT
  } msort_state_t;

endpackage

// ===== sv/msort_ram.sv =====
module msort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/merge_sort_batch_unit.sv =====
// Batch merge sorter. Loading takes one beat per cycle with busy low; the closing beat sets busy.
// Sort: ceil(log2 n) bottom-up passes over two ping-pong RAMs with one registered read port;
// in a pass each run starts in S_RUN, S_CAP_A and S_CAP_B, merges each element in S_MERGE and
// S_REFILL, and closes in S_NEXT. Results come one per cycle from S_EMIT through the registered
// RAM read and strobe, after the last pass (or after the closing beat of a one-element batch);
// the receiver cannot stall. Sync active-low reset: sequencer, count, strobe.
module merge_sort_batch_unit #(
  parameter int MAX_ITEMS = msort_pkg::MAX_ITEMS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  msort_pkg::msort_in_t   in_item,
  output logic                   out_strobe,
  output msort_pkg::msort_out_t  out_item
);

  import msort_pkg::*;

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W = CNT_W + 2;

  msort_state_t state_r, state_nxt;

  logic [IDX_W-1:0] cnt_r;
  logic [CNT_W-1:0] n_r;
  logic [CNT_W:0]   w_r;
  logic [CNT_W-1:0] lo_r, mid_r, hi_r, a_r, b_r, k_r;
  logic [IDX_W-1:0] e_r;
  logic             src_r;
  logic             took_a_r;
  logic signed [VALUE_BITS-1:0] a_head_r, b_head_r;
  logic             strobe_r, final_r;

  // RAM ports
  logic                  we0, we1;
  logic [IDX_W-1:0]      wa0, wa1, rd_addr;
  logic [VALUE_BITS-1:0] wd0, wd1, rd0, rd1;
  logic signed [VALUE_BITS-1:0] rdata;

  // Control terms
  logic             accept, close;
  logic [CNT_W-1:0] cnt_inc;
  logic             a_ok, b_ok, take_a;
  logic [SUM_W-1:0] sum1, sum2, w2, n_ext;
  logic [CNT_W-1:0] mid_calc, hi_calc;
  logic             pass_end, sort_done, emit_end;
  logic [CNT_W-1:0] a_inc, b_inc;
  logic signed [VALUE_BITS-1:0] merge_data;

  assign accept  = start && !busy;
  assign cnt_inc = CNT_W'(cnt_r) + CNT_W'(1);
  assign close   = in_item.last || (cnt_inc == CNT_W'(MAX_ITEMS));

  assign rdata   = src_r ? $signed(rd1) : $signed(rd0);

  // Compare unit: stable choice of the left run on equal keys
  assign a_ok    = a_r < mid_r;
  assign b_ok    = b_r < hi_r;
  assign take_a  = a_ok && (!b_ok || (a_head_r <= b_head_r));
  assign merge_data = take_a ? a_head_r : b_head_r;
  assign a_inc   = a_r + CNT_W'(1);
  assign b_inc   = b_r + CNT_W'(1);

  // Run bounds and pass stepping
  assign n_ext     = SUM_W'(n_r);
  assign sum1      = SUM_W'(lo_r) + SUM_W'(w_r);
  assign w2        = SUM_W'(w_r) << 1;
  assign sum2      = SUM_W'(lo_r) + w2;
  assign mid_calc  = (sum1 < n_ext) ? sum1[CNT_W-1:0] : n_r;
  assign hi_calc   = (sum2 < n_ext) ? sum2[CNT_W-1:0] : n_r;
  assign pass_end  = sum2 >= n_ext;
  assign sort_done = w2 >= n_ext;
  assign emit_end  = (CNT_W'(e_r) + CNT_W'(1)) == n_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && close) begin
          state_nxt = (cnt_r == '0) ? S_EMIT : S_RUN;
        end
      end
      S_RUN:    state_nxt = S_CAP_A;
      S_CAP_A:  state_nxt = S_CAP_B;
      S_CAP_B:  state_nxt = S_MERGE;
      S_MERGE:  state_nxt = S_REFILL;
      S_REFILL: state_nxt = (k_r == hi_r) ? S_NEXT : S_MERGE;
      S_NEXT:   state_nxt = (pass_end && sort_done) ? S_EMIT : S_RUN;
      S_EMIT:   state_nxt = emit_end ? S_IDLE : S_EMIT;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: busy and RAM control
  always_comb begin
    busy    = (state_r != S_IDLE);
    we0     = 1'b0;
    we1     = 1'b0;
    wa0     = k_r[IDX_W-1:0];
    wa1     = k_r[IDX_W-1:0];
    wd0     = merge_data;
    wd1     = merge_data;
    rd_addr = '0;
    case (state_r)
      S_IDLE: begin
        we0 = accept;
        wa0 = cnt_r;
        wd0 = in_item.value;
      end
      S_RUN:   rd_addr = lo_r[IDX_W-1:0];
      S_CAP_A: rd_addr = mid_r[IDX_W-1:0];
      S_MERGE: begin
        we0     = src_r;
        we1     = !src_r;
        rd_addr = take_a ? a_inc[IDX_W-1:0] : b_inc[IDX_W-1:0];
      end
      S_EMIT:  rd_addr = e_r;
      default: rd_addr = '0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == S_EMIT);
      if (accept) begin
        cnt_r <= close ? '0 : cnt_inc[IDX_W-1:0];
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    final_r <= emit_end;
    case (state_r)
      S_IDLE: begin
        if (accept && close) begin
          n_r   <= cnt_inc;
          w_r   <= (CNT_W+1)'(1);
          lo_r  <= '0;
          src_r <= 1'b0;
          e_r   <= '0;
        end
      end
      S_RUN: begin
        mid_r <= mid_calc;
        hi_r  <= hi_calc;
        a_r   <= lo_r;
        b_r   <= mid_calc;
        k_r   <= lo_r;
      end
      S_CAP_A: a_head_r <= rdata;
      S_CAP_B: b_head_r <= rdata;
      S_MERGE: begin
        took_a_r <= take_a;
        k_r      <= k_r + CNT_W'(1);
        if (take_a) begin
          a_r <= a_inc;
        end else begin
          b_r <= b_inc;
        end
      end
      S_REFILL: begin
        if (took_a_r) begin
          a_head_r <= rdata;
        end else begin
          b_head_r <= rdata;
        end
      end
      S_NEXT: begin
        e_r <= '0;
        if (pass_end) begin
          lo_r  <= '0;
          w_r   <= w2[CNT_W:0];
          src_r <= !src_r;
        end else begin
          lo_r  <= sum2[CNT_W-1:0];
        end
      end
      S_EMIT: e_r <= e_r + IDX_W'(1);
      default: begin
      end
    endcase
  end

  // Element store and scratch store, swapped in role each pass
  msort_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_elem_ram (
    .clk     (clk),
    .wr_en   (we0),
    .wr_addr (wa0),
    .wr_data (wd0),
    .rd_addr (rd_addr),
    .rd_data (rd0)
  );

  msort_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_scratch_ram (
    .clk     (clk),
    .wr_en   (we1),
    .wr_addr (wa1),
    .wr_data (wd1),
    .rd_addr (rd_addr),
    .rd_data (rd1)
  );

  // Result beat
  assign out_strobe            = strobe_r;
  assign out_item.sorted_value = rdata;
  assign out_item.final_res    = final_r;

  // Checks
  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_EMIT))
    else $error("result beat without emit read");

  a_merge_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE) |-> (k_r < hi_r) && (a_ok || b_ok))
    else $error("merge step beyond run end");

  a_run_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NEXT) |-> (a_r == mid_r) && (b_r == hi_r))
    else $error("run closed with elements left");

  a_final_ends_batch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.final_res) |=> !out_strobe)
    else $error("result beat after final");

endmodule
